// ===== hdl/vcc_pkg.sv =====
// Shared types and constants of the vending coin and change controller.
// Depends on nothing; used by vcc_ctrl, vcc_dp and the top level.
package vcc_pkg;

    localparam int MAX_COINS = 6;
    localparam int VAL_W     = 16;
    localparam int CNT_W     = 8;

    // Request codes on the input channel
    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_COIN  = 2'd1,
        REQ_LOAD  = 2'd2,
        REQ_BAD   = 2'd3
    } t_req;

    // Result kinds on the output channel
    typedef enum logic [2:0] {
        KIND_REJECT = 3'd0,
        KIND_AWAIT  = 3'd1,
        KIND_CHANGE = 3'd2,
        KIND_DONE   = 3'd3,
        KIND_SHORT  = 3'd4,
        KIND_CANCEL = 3'd5,
        KIND_LOADED = 3'd6
    } t_kind;

    typedef logic [VAL_W-1:0] t_val_arr [MAX_COINS];

    // Coin values after reset, smallest first
    localparam t_val_arr COIN_RESET = '{16'd10, 16'd20, 16'd50, 16'd100, 16'd200, 16'd500};

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic decode;
        logic sel;
        logic div_step;
        logic mul;
        logic emit_chg;
        logic emit_fin;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic go_pay;
        logic skip;
        logic idx_zero;
        logic div_last;
    } t_sts;

endpackage

// ===== hdl/vending_coin_and_change_controller_unit.sv =====
// Top level of the vending coin and change controller.
// Depends on vcc_pkg, vcc_ctrl and vcc_dp.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_req_type, i_amount, i_coin_slot
//  out     | output    | o_out_valid / i_out_stall | o_kind, o_coin_index, o_coin_count,
//          |           |                           | o_deposit_total, o_change_left, o_last
//  cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// Steps: an item that gives one result passes capture and decode, plus any wait for
// the output register. A payout adds per denomination a select step if skipped,
// else select, 16 divider steps, multiply and emit, then the final status beat;
// the divider yields one quotient bit per cycle.
// Reset: synchronous, active low; coin values return to 10/20/50/100/200/500 cents,
// stock, deposit and price clear, and the sale goes idle. No clearing pass.
// Stalls: the output register holds a beat while stalled; a new item is taken as
// soon as the sequencer is idle, even while the last beat still waits.
module vending_coin_and_change_controller_unit #(
    parameter int NUM_COINS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // request beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_amount,
    input  logic [2:0]  i_coin_slot,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_coin_index,
    output logic [7:0]  o_coin_count,
    output logic [15:0] o_deposit_total,
    output logic [15:0] o_change_left,
    output logic        o_last
);

    vcc_pkg::t_cmd cmd;
    vcc_pkg::t_sts sts;

    // Sequence capture, decode and the per-denomination payout loop
    vcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold coin values, stock and sale state; divide, multiply and drive result beats
    vcc_dp #(
        .NUM_COINS (NUM_COINS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_amount        (i_amount),
        .i_coin_slot     (i_coin_slot),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_coin_index    (o_coin_index),
        .o_coin_count    (o_coin_count),
        .o_deposit_total (o_deposit_total),
        .o_change_left   (o_change_left),
        .o_last          (o_last)
    );

endmodule

// ===== hdl/vcc_ctrl.sv =====
// Sequencer of the vending coin and change controller.
// Depends on vcc_pkg for the command and status structs.
module vcc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  vcc_pkg::t_sts i_sts,
    output vcc_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEL,
        ST_DIV,
        ST_MUL,
        ST_EMIT,
        ST_FINAL
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_sts.out_free) begin
                    o_cmd.decode = 1'b1;
                    n_state      = i_sts.go_pay ? ST_SEL : ST_IDLE;
                end
            end
            ST_SEL: begin
                o_cmd.sel = 1'b1;
                if (!i_sts.skip)          n_state = ST_DIV;
                else if (i_sts.idx_zero)  n_state = ST_FINAL;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_chg = 1'b1;
                    n_state        = i_sts.idx_zero ? ST_FINAL : ST_SEL;
                end
            end
            ST_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_fin = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != ST_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

// ===== hdl/vcc_dp.sv =====
// Datapath of the vending coin and change controller: coin values, stock,
// sale state, bit-serial divider, payout multiplier and output register. Uses vcc_pkg.
module vcc_dp #(
    parameter int NUM_COINS = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vcc_pkg::t_cmd i_cmd,
    output vcc_pkg::t_sts o_sts,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic [1:0]    i_req_type,
    input  logic [15:0]   i_amount,
    input  logic [2:0]    i_coin_slot,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [2:0]    o_kind,
    output logic [2:0]    o_coin_index,
    output logic [7:0]    o_coin_count,
    output logic [15:0]   o_deposit_total,
    output logic [15:0]   o_change_left,
    output logic          o_last
);

    localparam int               IDX_W   = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(NUM_COINS - 1);
    localparam logic [3:0]       NC      = 4'(NUM_COINS);

    // Configuration and stock
    logic [15:0] r_val   [NUM_COINS];
    logic [7:0]  r_stock [NUM_COINS];

    // Sale state
    logic [15:0] r_deposit, r_price;
    logic        r_active;

    // Captured request
    vcc_pkg::t_req r_req;
    logic [15:0]   r_amt;
    logic [2:0]    r_slot;

    // Payout
    logic [IDX_W-1:0] r_idx;
    logic [15:0]      r_change, r_dq, r_rem, r_prod;
    logic [3:0]       r_div_cnt;
    logic [7:0]       r_n;

    // Output register
    logic          r_out_valid, r_out_last;
    vcc_pkg::t_kind r_out_kind;
    logic [2:0]    r_out_cidx;
    logic [7:0]    r_out_cnt;
    logic [15:0]   r_out_dep, r_out_left;

    logic             m_hit;
    logic [IDX_W-1:0] m_idx;
    logic [IDX_W-1:0] stk_addr;
    logic [7:0]       stk_rd;
    logic [15:0]      v;
    logic             slot_ok;
    logic [16:0]      ld_sum, dep_sum, div_t;
    logic [7:0]       ld_new, coin_stk, pay_n;
    logic [15:0]      dep_new, chg_new;
    logic [23:0]      prod_full;
    logic             div_ge;

    vcc_pkg::t_kind d_kind;
    logic [15:0]    d_dep;
    logic [7:0]     d_cnt;
    logic [2:0]     d_cidx;
    logic           d_pay, d_acc, d_stk_we;
    logic [7:0]     d_stk_val;

    logic           e_emit;
    vcc_pkg::t_kind e_kind;
    logic [2:0]     e_cidx;
    logic [7:0]     e_cnt;
    logic [15:0]    e_dep, e_left;
    logic           e_last;

    logic           stk_we;
    logic [7:0]     stk_wval;

    // Highest index whose value matches the coin
    always_comb begin
        m_hit = 1'b0;
        m_idx = '0;
        for (int i = 0; i < NUM_COINS; i++) begin
            if (r_val[i] == r_amt) begin
                m_hit = 1'b1;
                m_idx = IDX_W'(i);
            end
        end
    end

    assign stk_addr = i_cmd.decode ? ((r_req == vcc_pkg::REQ_LOAD) ? r_slot[IDX_W-1:0] : m_idx)
                                   : r_idx;
    assign stk_rd   = r_stock[stk_addr];
    assign v        = r_val[r_idx];

    assign slot_ok  = {1'b0, r_slot} < NC;
    assign ld_sum   = {9'd0, stk_rd} + {1'b0, r_amt};
    assign ld_new   = (ld_sum > 17'd255) ? 8'hFF : ld_sum[7:0];
    assign coin_stk = (stk_rd == 8'hFF) ? 8'hFF : stk_rd + 8'd1;
    assign dep_sum  = {1'b0, r_deposit} + {1'b0, r_amt};
    assign dep_new  = dep_sum[16] ? 16'hFFFF : dep_sum[15:0];

    // Decide the single-result items and whether a coin starts a payout
    always_comb begin
        d_kind    = vcc_pkg::KIND_REJECT;
        d_dep     = r_deposit;
        d_cnt     = '0;
        d_cidx    = '0;
        d_pay     = 1'b0;
        d_acc     = 1'b0;
        d_stk_we  = 1'b0;
        d_stk_val = ld_new;
        unique case (r_req)
            vcc_pkg::REQ_START: begin
                d_kind = vcc_pkg::KIND_AWAIT;
                d_dep  = '0;
            end
            vcc_pkg::REQ_LOAD: begin
                if (slot_ok) begin
                    d_kind   = vcc_pkg::KIND_LOADED;
                    d_cidx   = r_slot;
                    d_cnt    = ld_new;
                    d_stk_we = 1'b1;
                end
            end
            vcc_pkg::REQ_COIN: begin
                if (r_amt == 16'd0) begin
                    d_kind = vcc_pkg::KIND_CANCEL;
                    d_dep  = '0;
                end else if (r_active && m_hit) begin
                    d_acc     = 1'b1;
                    d_stk_we  = 1'b1;
                    d_stk_val = coin_stk;
                    d_dep     = dep_new;
                    if (dep_new < r_price) d_kind = vcc_pkg::KIND_AWAIT;
                    else                   d_pay  = 1'b1;
                end
            end
            vcc_pkg::REQ_BAD: d_kind = vcc_pkg::KIND_REJECT;
            default:          d_kind = vcc_pkg::KIND_REJECT;
        endcase
    end

    // Divider step and payout arithmetic
    assign div_t     = {r_rem, r_dq[15]};
    assign div_ge    = div_t >= {1'b0, v};
    assign pay_n     = (r_dq > {8'd0, stk_rd}) ? stk_rd : r_dq[7:0];
    assign prod_full = 24'(pay_n) * 24'(v);
    assign chg_new   = r_change - r_prod;

    // Single stock write port
    always_comb begin
        stk_we   = 1'b0;
        stk_wval = d_stk_val;
        if (i_cmd.decode) begin
            stk_we = d_stk_we;
        end else if (i_cmd.emit_chg) begin
            stk_we   = 1'b1;
            stk_wval = stk_rd - r_n;
        end
    end

    // Output beat selection
    always_comb begin
        e_emit = 1'b0;
        e_kind = d_kind;
        e_cidx = d_cidx;
        e_cnt  = d_cnt;
        e_dep  = d_dep;
        e_left = '0;
        e_last = 1'b1;
        if (i_cmd.decode && !d_pay) begin
            e_emit = 1'b1;
        end else if (i_cmd.emit_chg) begin
            e_emit = 1'b1;
            e_kind = vcc_pkg::KIND_CHANGE;
            e_cidx = 3'(r_idx);
            e_cnt  = r_n;
            e_dep  = r_deposit;
            e_left = chg_new;
            e_last = 1'b0;
        end else if (i_cmd.emit_fin) begin
            e_emit = 1'b1;
            e_kind = (r_change == 16'd0) ? vcc_pkg::KIND_DONE : vcc_pkg::KIND_SHORT;
            e_cidx = '0;
            e_cnt  = '0;
            e_dep  = r_deposit;
            e_left = r_change;
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COINS; i++) begin
                r_val[i]   <= vcc_pkg::COIN_RESET[i];
                r_stock[i] <= '0;
            end
            r_deposit   <= '0;
            r_price     <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && ({1'b0, i_cfg_idx} < NC)) begin
                r_val[i_cfg_idx[IDX_W-1:0]] <= i_cfg_data;
            end
            if (stk_we) begin
                r_stock[stk_addr] <= stk_wval;
            end
            if (i_cmd.decode) begin
                if (r_req == vcc_pkg::REQ_START) begin
                    r_price   <= r_amt;
                    r_deposit <= '0;
                    r_active  <= 1'b1;
                end else if (r_req == vcc_pkg::REQ_COIN && r_amt == 16'd0) begin
                    r_deposit <= '0;
                    r_active  <= 1'b0;
                end else if (d_acc) begin
                    r_deposit <= dep_new;
                end
            end
            if (i_cmd.emit_fin) begin
                r_deposit <= '0;
                r_active  <= 1'b0;
            end
            if (e_emit)            r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= vcc_pkg::t_req'(i_req_type);
            r_amt  <= i_amount;
            r_slot <= i_coin_slot;
        end
        if (i_cmd.decode) begin
            r_change <= dep_new - r_price;
            r_idx    <= TOP_IDX;
        end
        if (i_cmd.sel) begin
            if (o_sts.skip) begin
                if (r_idx != '0) r_idx <= r_idx - 1'b1;
            end else begin
                r_dq      <= r_change;
                r_rem     <= '0;
                r_div_cnt <= 4'd15;
            end
        end
        if (i_cmd.div_step) begin
            r_rem     <= div_ge ? 16'(div_t - {1'b0, v}) : div_t[15:0];
            r_dq      <= {r_dq[14:0], div_ge};
            r_div_cnt <= r_div_cnt - 4'd1;
        end
        if (i_cmd.mul) begin
            r_n    <= pay_n;
            r_prod <= prod_full[15:0];
        end
        if (i_cmd.emit_chg) begin
            r_change <= chg_new;
            if (r_idx != '0) r_idx <= r_idx - 1'b1;
        end
        if (e_emit) begin
            r_out_kind <= e_kind;
            r_out_cidx <= e_cidx;
            r_out_cnt  <= e_cnt;
            r_out_dep  <= e_dep;
            r_out_left <= e_left;
            r_out_last <= e_last;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.go_pay   = d_pay;
    assign o_sts.skip     = (v == 16'd0) || (v > r_change) || (stk_rd == 8'd0);
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.div_last = (r_div_cnt == 4'd0);

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_coin_index    = r_out_cidx;
    assign o_coin_count    = r_out_cnt;
    assign o_deposit_total = r_out_dep;
    assign o_change_left   = r_out_left;
    assign o_last          = r_out_last;

    a_change_beat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == vcc_pkg::KIND_CHANGE |-> r_out_cnt != 8'd0 && !r_out_last)
        else $error("change beat with zero coins or marked last");

    a_prod_fits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_chg |-> r_prod <= r_change)
        else $error("payout exceeds change owed");

    a_done_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == vcc_pkg::KIND_DONE |-> r_out_left == 16'd0)
        else $error("done reported with change owed");

    a_sale_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_fin |=> !r_active && r_deposit == 16'd0)
        else $error("sale not closed after final beat");

endmodule
